// ----- design/bstk_pkg.sv -----
// ============================================================================
// bstk_pkg
// Shared types, operation codes and status codes of the bounded stack block.
// ============================================================================
package bstk_pkg;

    localparam int BSTK_DEPTH = 8;
    localparam int KIND_W     = 3;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 7;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MIN    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MAX    = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_SCAN,
        SEQ_RESP
    } seq_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         pos;
        logic                     last;
    } res_t;

    // one result beat handed from the sequencer to the output stage
    typedef struct packed {
        logic valid;
        res_t res;
    } emit_t;

endpackage

// ----- design/bstk_ram.sv -----
// ============================================================================
// bstk_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data when not enabled
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/bstk_cmp.sv -----
// ============================================================================
// bstk_cmp
// Shared word comparator: equality and signed less-than.
// ============================================================================
module bstk_cmp
    import bstk_pkg::*;
(
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic                     eq,
    output logic                     lt
);

    assign eq = (a == b);
    assign lt = (a < b);

endmodule

// ----- design/bstk_seq.sv -----
// ============================================================================
// bstk_seq
// Sequencer: decodes one operation, drives the entry RAM and the shared comparator, scans
// occupied entries one per cycle unless a search match stalls, and issues result beats.
// ============================================================================
module bstk_seq
    import bstk_pkg::*;
#(
    parameter int DEPTH = BSTK_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [KIND_W-1:0]        in_kind,
    input  logic signed [DATA_W-1:0] in_operand,
    // entry RAM
    output logic                     ram_wr_en,
    output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
    output logic [DATA_W-1:0]        ram_wr_data,
    output logic                     ram_rd_en,
    output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
    input  logic [DATA_W-1:0]        ram_rd_data,
    // shared comparator
    output logic signed [DATA_W-1:0] cmp_a,
    output logic signed [DATA_W-1:0] cmp_b,
    input  logic                     cmp_eq,
    input  logic                     cmp_lt,
    // output stage
    input  logic                     out_free,
    output emit_t                    emit
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    seq_state_t               state_reg,    state_next;
    logic [CNT_W-1:0]         fill_reg,     fill_next;
    logic [ADDR_W-1:0]        idx_reg,      idx_next;
    logic [KIND_W-1:0]        kind_reg,     kind_next;
    logic signed [DATA_W-1:0] operand_reg,  operand_next;
    logic signed [DATA_W-1:0] best_reg,     best_next;
    logic                     found_reg,    found_next;
    logic [POS_W-1:0]         pend_pos_reg, pend_pos_next;
    res_t                     res_reg,      res_next;

    logic [CNT_W-1:0]         fill_m1;
    logic [ADDR_W-1:0]        top_addr;
    logic                     is_last;
    logic                     is_search;
    logic                     match;
    logic                     take;
    logic                     stall;
    logic [POS_W-1:0]         idx_pos;
    logic signed [DATA_W-1:0] new_best;

    assign fill_m1   = fill_reg - CNT_W'(1);
    assign top_addr  = ADDR_W'(fill_m1);
    assign is_last   = (idx_reg == top_addr);
    assign is_search = (kind_reg == KIND_SEARCH);
    assign idx_pos   = POS_W'(idx_reg) + POS_W'(1);

    assign cmp_a = ram_rd_data;
    assign cmp_b = is_search ? operand_reg : best_reg;

    assign match    = cmp_eq;
    assign take     = (idx_reg == '0) ||
                      ((kind_reg == KIND_MIN) ? cmp_lt : (!cmp_lt && !cmp_eq));
    assign new_best = take ? $signed(ram_rd_data) : best_reg;
    // a second match pushes out the held one, which needs a free output slot
    assign stall    = match && found_reg && !out_free;

    assign in_ready = (state_reg == SEQ_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
        idx_reg      <= idx_next;
        kind_reg     <= kind_next;
        operand_reg  <= operand_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
        pend_pos_reg <= pend_pos_next;
        res_reg      <= res_next;
    end

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        kind_next     = kind_reg;
        operand_next  = operand_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        pend_pos_next = pend_pos_reg;
        res_next      = res_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = ADDR_W'(fill_reg);
        ram_wr_data   = in_operand;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = '0;
        emit          = '0;

        case (state_reg)
            SEQ_IDLE: begin
                if (in_valid) begin
                    kind_next    = in_kind;
                    operand_next = in_operand;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    res_next     = '{status: ST_OK, value: '0, pos: '0, last: 1'b1};
                    case (in_kind)
                        KIND_PUSH: begin
                            if (fill_reg == CNT_W'(DEPTH)) begin
                                res_next.status = ST_OVERFLOW;
                            end else begin
                                ram_wr_en      = 1'b1;
                                fill_next      = fill_reg + CNT_W'(1);
                                res_next.value = in_operand;
                                res_next.pos   = POS_W'(fill_reg) + POS_W'(1);
                            end
                            state_next = SEQ_RESP;
                        end
                        KIND_POP, KIND_PEEK: begin
                            if (fill_reg == '0) begin
                                res_next.status = ST_EMPTY;
                                state_next      = SEQ_RESP;
                            end else begin
                                ram_rd_en    = 1'b1;
                                ram_rd_addr  = top_addr;
                                res_next.pos = POS_W'(fill_reg);
                                if (in_kind == KIND_POP) begin
                                    fill_next = fill_m1;
                                end
                                state_next = SEQ_READ;
                            end
                        end
                        KIND_SEARCH, KIND_MIN, KIND_MAX: begin
                            if (fill_reg == '0) begin
                                res_next.status = (in_kind == KIND_SEARCH) ?
                                                  ST_NOT_FOUND : ST_EMPTY;
                                state_next      = SEQ_RESP;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                state_next  = SEQ_SCAN;
                            end
                        end
                        default: begin
                            // unused code: drop it
                            state_next = SEQ_IDLE;
                        end
                    endcase
                end
            end

            SEQ_READ: begin
                res_next.value = ram_rd_data;
                state_next     = SEQ_RESP;
            end

            SEQ_SCAN: begin
                if (is_search) begin
                    if (!stall) begin
                        if (match && found_reg) begin
                            emit.valid = 1'b1;
                            emit.res   = '{status: ST_OK, value: operand_reg,
                                           pos: pend_pos_reg, last: 1'b0};
                        end
                        if (match) begin
                            found_next    = 1'b1;
                            pend_pos_next = idx_pos;
                        end
                        if (is_last) begin
                            if (match) begin
                                res_next = '{status: ST_OK, value: operand_reg,
                                             pos: idx_pos, last: 1'b1};
                            end else if (found_reg) begin
                                res_next = '{status: ST_OK, value: operand_reg,
                                             pos: pend_pos_reg, last: 1'b1};
                            end else begin
                                res_next = '{status: ST_NOT_FOUND, value: '0,
                                             pos: '0, last: 1'b1};
                            end
                            state_next = SEQ_RESP;
                        end else begin
                            idx_next    = idx_reg + ADDR_W'(1);
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = idx_reg + ADDR_W'(1);
                        end
                    end
                end else begin
                    best_next = new_best;
                    if (is_last) begin
                        res_next   = '{status: ST_OK, value: new_best, pos: '0, last: 1'b1};
                        state_next = SEQ_RESP;
                    end else begin
                        idx_next    = idx_reg + ADDR_W'(1);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_reg + ADDR_W'(1);
                    end
                end
            end

            SEQ_RESP: begin
                if (out_free) begin
                    emit.valid = 1'b1;
                    emit.res   = res_reg;
                    state_next = SEQ_IDLE;
                end
            end

            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

// ----- design/bounded_stack_with_search_min_max.sv -----
// ============================================================================
// bounded_stack_with_search_min_max
// Fixed-depth LIFO of signed 32-bit words with push, pop, peek, search,
// minimum and maximum operations.
// ============================================================================
//
//   channel   dir   handshake           payload
//   -------   ---   -----------------   -----------------------------------------
//   s_        in    s_valid / s_ready   s_kind, s_operand_value
//   m_        out   m_valid / m_ready   m_status, m_result_value, m_position,
//                                       m_last_result
//
// Push writes the entry RAM, then responds; pop and peek read the top entry
// first; search, min and max scan one entry per cycle from the single read
// port of the entry RAM through the shared comparator. Each extra search match
// adds a beat and may hold the scan; back-pressure on m_ stalls responses.
// Reset (aresetn low, synchronous) empties the stack and the output register;
// the entry RAM is not cleared, as only entries below the fill count are read.
// s_ready is high only while the sequencer is idle; one result beat may still
// wait in the output register while the next operation is taken.
//
module bounded_stack_with_search_min_max
    import bstk_pkg::*;
#(
    parameter int DEPTH = BSTK_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // operation beats
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [KIND_W-1:0]          s_kind,
    input  logic signed [DATA_W-1:0]   s_operand_value,
    // result beats
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [DATA_W-1:0]   m_result_value,
    output logic [POS_W-1:0]           m_position,
    output logic                       m_last_result
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic                     ram_wr_en;
    logic [ADDR_W-1:0]        ram_wr_addr;
    logic [DATA_W-1:0]        ram_wr_data;
    logic                     ram_rd_en;
    logic [ADDR_W-1:0]        ram_rd_addr;
    logic [DATA_W-1:0]        ram_rd_data;
    logic signed [DATA_W-1:0] cmp_a;
    logic signed [DATA_W-1:0] cmp_b;
    logic                     cmp_eq;
    logic                     cmp_lt;
    logic                     out_free;
    emit_t                    emit;

    logic                     m_valid_reg, m_valid_next;
    res_t                     m_res_reg,   m_res_next;

    // sequencer: decode, scan and issue result beats
    bstk_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_kind     (s_kind),
        .in_operand  (s_operand_value),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .cmp_a       (cmp_a),
        .cmp_b       (cmp_b),
        .cmp_eq      (cmp_eq),
        .cmp_lt      (cmp_lt),
        .out_free    (out_free),
        .emit        (emit)
    );

    // stack entries
    bstk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // one comparator serves search equality and min/max ordering
    bstk_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .eq (cmp_eq),
        .lt (cmp_lt)
    );

    // output register: free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (emit.valid) begin
            // load a new beat; the sequencer only offers one when out_free
            m_valid_next = 1'b1;
            m_res_next   = emit.res;
        end else if (m_ready) begin
            // drop the beat just taken
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_res_reg.status;
    assign m_result_value = m_res_reg.value;
    assign m_position     = m_res_reg.pos;
    assign m_last_result  = m_res_reg.last;

endmodule

// ----- design/bstk_chk.sv -----
// ============================================================================
// bstk_chk
// Port-level checker for the bounded stack block, bound to the top level.
// ============================================================================
module bstk_chk
    import bstk_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic [KIND_W-1:0]        s_kind,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [STATUS_W-1:0]      m_status,
    input logic signed [DATA_W-1:0] m_result_value,
    input logic [POS_W-1:0]         m_position,
    input logic                     m_last_result
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_result_value) && $stable(m_position) && $stable(m_last_result))
        else $error("result beat changed while stalled");

    // every valid operation keeps the sequencer busy in the cycle after it is taken
    a_busy_after_op: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_PUSH || s_kind == KIND_POP ||
        s_kind == KIND_PEEK || s_kind == KIND_SEARCH || s_kind == KIND_MIN ||
        s_kind == KIND_MAX) |=> !s_ready)
        else $error("input taken again before the operation finished");

    // error results are single beats with cleared value and position
    a_err_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |->
        m_last_result && m_result_value == '0 && m_position == '0)
        else $error("error result beat malformed");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat present after reset");

endmodule

bind bounded_stack_with_search_min_max bstk_chk u_bstk_chk (.*);

// ----- dv/stack_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_checker
// Watches the operation and result channels of the bounded stack, keeps its
// own copy of the stack contents, and compares every result beat against
// the oldest expected beat.
// ----------------------------------------------------------------------------
module stack_checker
    import bstk_pkg::*;
#(
    parameter int DEPTH = BSTK_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [KIND_W-1:0]        s_kind,
    input  logic signed [DATA_W-1:0] s_operand_value,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [STATUS_W-1:0]      m_status,
    input  logic signed [DATA_W-1:0] m_result_value,
    input  logic [POS_W-1:0]         m_position,
    input  logic                     m_last_result,
    output int                       fail_count,
    output int                       pending_beats,
    output int                       beats_checked
);

    logic signed [DATA_W-1:0] stack_words [DEPTH];
    int                       stack_fill;
    res_t                     expected_results [$];

    function automatic void queue_result(input logic [STATUS_W-1:0] status,
                                         input logic signed [DATA_W-1:0] value,
                                         input int pos, input logic last);
        res_t beat;
        beat.status = status;
        beat.value  = value;
        beat.pos    = POS_W'(pos);
        beat.last   = last;
        expected_results.push_back(beat);
    endfunction

    // work out the result beats of one accepted operation and update the stack
    function automatic void predict_stack_op(input logic [KIND_W-1:0] kind,
                                             input logic signed [DATA_W-1:0] operand);
        logic signed [DATA_W-1:0] best;
        int                       hits;
        int                       first_q;
        case (kind)
            KIND_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    queue_result(ST_OVERFLOW, '0, 0, 1'b1);
                end else begin
                    stack_words[stack_fill] = operand;
                    stack_fill++;
                    queue_result(ST_OK, operand, stack_fill, 1'b1);
                end
            end
            KIND_POP, KIND_PEEK: begin
                if (stack_fill == 0) begin
                    queue_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    queue_result(ST_OK, stack_words[stack_fill-1], stack_fill, 1'b1);
                    if (kind == KIND_POP)
                        stack_fill--;
                end
            end
            KIND_SEARCH: begin
                hits    = 0;
                first_q = expected_results.size();
                for (int i = 0; i < stack_fill; i++) begin
                    if (stack_words[i] == operand) begin
                        queue_result(ST_OK, operand, i + 1, 1'b0);
                        hits++;
                    end
                end
                if (hits == 0)
                    queue_result(ST_NOT_FOUND, '0, 0, 1'b1);
                else
                    expected_results[first_q + hits - 1].last = 1'b1;
            end
            KIND_MIN, KIND_MAX: begin
                if (stack_fill == 0) begin
                    queue_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    best = stack_words[0];
                    for (int i = 1; i < stack_fill; i++) begin
                        if (kind == KIND_MIN ? (stack_words[i] < best)
                                             : (best < stack_words[i]))
                            best = stack_words[i];
                    end
                    queue_result(ST_OK, best, 0, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            stack_fill    = 0;
            fail_count    = 0;
            beats_checked = 0;
            expected_results.delete();
        end else begin
            if (s_valid && s_ready)
                predict_stack_op(s_kind, s_operand_value);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat: status %0d value %0d position %0d",
                           m_status, m_result_value, m_position);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    beats_checked++;
                    if (m_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_status);
                        fail_count++;
                    end
                    if (m_result_value !== want.value) begin
                        $error("result_value mismatch: expected %0d, actual %0d",
                               want.value, m_result_value);
                        fail_count++;
                    end
                    if (m_position !== want.pos) begin
                        $error("position mismatch: expected %0d, actual %0d",
                               want.pos, m_position);
                        fail_count++;
                    end
                    if (m_last_result !== want.last) begin
                        $error("last_result mismatch: expected %0d, actual %0d",
                               want.last, m_last_result);
                        fail_count++;
                    end
                end
            end
        end
        pending_beats = expected_results.size();
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives operation beats into the bounded stack: a directed opening that hits
// empty, full, extreme words and duplicate search hits, then random traffic
// under four pacing phases. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import bstk_pkg::*;

    localparam int DEPTH        = BSTK_DEPTH;
    localparam int PHASE_ITEMS  = 110;
    // slowest op is a full-stack scan with every entry matching, each beat
    // possibly stalled; allow a wide margin over that worst case
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4 * DEPTH + 16;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [KIND_W-1:0]        s_kind = KIND_PUSH;
    logic signed [DATA_W-1:0] s_operand_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [STATUS_W-1:0]      m_status;
    logic signed [DATA_W-1:0] m_result_value;
    logic [POS_W-1:0]         m_position;
    logic                     m_last_result;

    int fail_count;
    int pending_beats;
    int beats_checked;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int kind_sent [8];

    // small set of recurring words so searches find repeated hits
    logic signed [DATA_W-1:0] word_pool [6];

    // 125 MHz clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    bounded_stack_with_search_min_max #(.DEPTH(DEPTH)) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_operand_value (s_operand_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_result_value  (m_result_value),
        .m_position      (m_position),
        .m_last_result   (m_last_result)
    );

    stack_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_operand_value (s_operand_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_result_value  (m_result_value),
        .m_position      (m_position),
        .m_last_result   (m_last_result),
        .fail_count      (fail_count),
        .pending_beats   (pending_beats),
        .beats_checked   (beats_checked)
    );

    // Receiver back-pressure: redraw ready every falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d result beats still expected",
                     cycle_count, pending_beats);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one operation beat; hold valid and payload until accepted.
    task automatic send_op(input logic [KIND_W-1:0] kind,
                           input logic signed [DATA_W-1:0] operand);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_kind          = kind;
        s_operand_value = operand;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        kind_sent[kind]++;
        @(negedge aclk);
    endtask

    // Mostly recurring words, some extremes, the rest fully random.
    function automatic logic signed [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return word_pool[$urandom_range(5)];
        if (r < 62) begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return '0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Alternate between filling and draining so both full and empty come up.
    function automatic logic [KIND_W-1:0] pick_kind(input bit filling);
        int r;
        r = $urandom_range(99);
        if (r < (filling ? 50 : 20)) return KIND_PUSH;
        if (r < (filling ? 60 : 55)) return KIND_POP;
        if (r < (filling ? 66 : 62)) return KIND_PEEK;
        if (r < (filling ? 82 : 78)) return KIND_SEARCH;
        if (r < (filling ? 89 : 85)) return KIND_MIN;
        if (r < (filling ? 96 : 92)) return KIND_MAX;
        return KIND_W'(6 + $urandom_range(1));
    endfunction

    initial begin
        int               phase_idle [4];
        int               phase_stall [4];
        int               counted;
        logic [KIND_W-1:0] kind;

        phase_idle  = '{0, 63, 0, 17};
        phase_stall = '{0, 0, 63, 17};
        foreach (kind_sent[k])
            kind_sent[k] = 0;
        word_pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 5, 32'sh1234_5678};

        // hold reset low, then release it on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: every operation but push against an empty stack.
        send_op(KIND_MIN, 0);
        send_op(KIND_MAX, 0);
        send_op(KIND_POP, 0);
        send_op(KIND_PEEK, 0);
        send_op(KIND_SEARCH, 32'sh7FFF_FFFF);

        // Fill with extreme words and duplicates, then push once more to overflow.
        send_op(KIND_PUSH, 32'sh8000_0000);
        send_op(KIND_PUSH, 32'sh7FFF_FFFF);
        send_op(KIND_PUSH, 0);
        send_op(KIND_PUSH, -1);
        send_op(KIND_PUSH, 5);
        send_op(KIND_PUSH, 5);
        send_op(KIND_PUSH, 32'sh7FFF_FFFF);
        send_op(KIND_PUSH, 1);
        send_op(KIND_PUSH, 123);

        // Searches with several hits, one with none; scans over a full stack.
        send_op(KIND_SEARCH, 32'sh7FFF_FFFF);
        send_op(KIND_SEARCH, 5);
        send_op(KIND_SEARCH, 42);
        send_op(KIND_MIN, 0);
        send_op(KIND_MAX, 0);
        send_op(KIND_PEEK, 0);
        send_op(KIND_POP, 0);

        // Unused operation codes must be dropped silently.
        send_op(KIND_W'(6), 32'shFFFF_FFFF);
        send_op(KIND_W'(7), 32'sh5555_5555);
        send_op(KIND_POP, 0);

        // Random traffic, one pacing setting per phase.
        for (int p = 0; p < 4; p++) begin
            // pause the sender until every outstanding result has drained
            s_valid = 1'b0;
            while (pending_beats != 0)
                @(negedge aclk);
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if (counted % 30 == 29)
                    word_pool[$urandom_range(5)] = $urandom;
                kind = pick_kind(((counted / 24) % 2) == 0);
                send_op(kind, pick_word());
                if (kind <= KIND_MAX)
                    counted++;
            end
        end
        s_valid = 1'b0;

        // Drain: wait out every expected beat, then a margin for strays.
        while (pending_beats != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d operation beats: push %0d, pop %0d, peek %0d, search %0d,",
                 kind_sent[0] + kind_sent[1] + kind_sent[2] + kind_sent[3]
                 + kind_sent[4] + kind_sent[5] + kind_sent[6] + kind_sent[7],
                 kind_sent[KIND_PUSH], kind_sent[KIND_POP], kind_sent[KIND_PEEK],
                 kind_sent[KIND_SEARCH]);
        $display("  min %0d, max %0d, unused codes %0d; %0d result beats compared",
                 kind_sent[KIND_MIN], kind_sent[KIND_MAX], kind_sent[6] + kind_sent[7],
                 beats_checked);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/bstk_pkg.sv
design/bstk_ram.sv
design/bstk_cmp.sv
design/bstk_seq.sv
design/bounded_stack_with_search_min_max.sv
design/bstk_chk.sv
dv/stack_checker.sv
dv/tb_top.sv
